// ----- hdl/assert_macros.svh -----
// assertion macros for the rtl files
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/md2_pkg.sv -----
// shared types, constants and the pi substitution table of the md2 engine
// no dependencies; used by md2_compress and md2_hash_engine_top
package md2_pkg;

  localparam int BLK_BYTES  = 16;
  localparam int WORK_BYTES = 48;
  localparam int ROUNDS     = 18;

  // command codes of the input word
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       last_byte;
  } out_t;

  typedef logic [BLK_BYTES-1:0][7:0] block_t;

  // control from the sequencer to the compression unit
  typedef struct packed {
    logic start;
    logic clear;
  } cmp_ctl_t;

  localparam logic [7:0] PI_SBOX [256] = '{
    8'h29, 8'h2E, 8'h43, 8'hC9, 8'hA2, 8'hD8, 8'h7C, 8'h01,
    8'h3D, 8'h36, 8'h54, 8'hA1, 8'hEC, 8'hF0, 8'h06, 8'h13,
    8'h62, 8'hA7, 8'h05, 8'hF3, 8'hC0, 8'hC7, 8'h73, 8'h8C,
    8'h98, 8'h93, 8'h2B, 8'hD9, 8'hBC, 8'h4C, 8'h82, 8'hCA,
    8'h1E, 8'h9B, 8'h57, 8'h3C, 8'hFD, 8'hD4, 8'hE0, 8'h16,
    8'h67, 8'h42, 8'h6F, 8'h18, 8'h8A, 8'h17, 8'hE5, 8'h12,
    8'hBE, 8'h4E, 8'hC4, 8'hD6, 8'hDA, 8'h9E, 8'hDE, 8'h49,
    8'hA0, 8'hFB, 8'hF5, 8'h8E, 8'hBB, 8'h2F, 8'hEE, 8'h7A,
    8'hA9, 8'h68, 8'h79, 8'h91, 8'h15, 8'hB2, 8'h07, 8'h3F,
    8'h94, 8'hC2, 8'h10, 8'h89, 8'h0B, 8'h22, 8'h5F, 8'h21,
    8'h80, 8'h7F, 8'h5D, 8'h9A, 8'h5A, 8'h90, 8'h32, 8'h27,
    8'h35, 8'h3E, 8'hCC, 8'hE7, 8'hBF, 8'hF7, 8'h97, 8'h03,
    8'hFF, 8'h19, 8'h30, 8'hB3, 8'h48, 8'hA5, 8'hB5, 8'hD1,
    8'hD7, 8'h5E, 8'h92, 8'h2A, 8'hAC, 8'h56, 8'hAA, 8'hC6,
    8'h4F, 8'hB8, 8'h38, 8'hD2, 8'h96, 8'hA4, 8'h7D, 8'hB6,
    8'h76, 8'hFC, 8'h6B, 8'hE2, 8'h9C, 8'h74, 8'h04, 8'hF1,
    8'h45, 8'h9D, 8'h70, 8'h59, 8'h64, 8'h71, 8'h87, 8'h20,
    8'h86, 8'h5B, 8'hCF, 8'h65, 8'hE6, 8'h2D, 8'hA8, 8'h02,
    8'h1B, 8'h60, 8'h25, 8'hAD, 8'hAE, 8'hB0, 8'hB9, 8'hF6,
    8'h1C, 8'h46, 8'h61, 8'h69, 8'h34, 8'h40, 8'h7E, 8'h0F,
    8'h55, 8'h47, 8'hA3, 8'h23, 8'hDD, 8'h51, 8'hAF, 8'h3A,
    8'hC3, 8'h5C, 8'hF9, 8'hCE, 8'hBA, 8'hC5, 8'hEA, 8'h26,
    8'h2C, 8'h53, 8'h0D, 8'h6E, 8'h85, 8'h28, 8'h84, 8'h09,
    8'hD3, 8'hDF, 8'hCD, 8'hF4, 8'h41, 8'h81, 8'h4D, 8'h52,
    8'h6A, 8'hDC, 8'h37, 8'hC8, 8'h6C, 8'hC1, 8'hAB, 8'hFA,
    8'h24, 8'hE1, 8'h7B, 8'h08, 8'h0C, 8'hBD, 8'hB1, 8'h4A,
    8'h78, 8'h88, 8'h95, 8'h8B, 8'hE3, 8'h63, 8'hE8, 8'h6D,
    8'hE9, 8'hCB, 8'hD5, 8'hFE, 8'h3B, 8'h00, 8'h1D, 8'h39,
    8'hF2, 8'hEF, 8'hB7, 8'h0E, 8'h66, 8'h58, 8'hD0, 8'hE4,
    8'hA6, 8'h77, 8'h72, 8'hF8, 8'hEB, 8'h75, 8'h4B, 8'h0A,
    8'h31, 8'h44, 8'h50, 8'hB4, 8'h8F, 8'hED, 8'h1F, 8'h1A,
    8'hDB, 8'h99, 8'h8D, 8'h33, 8'h9F, 8'h11, 8'h83, 8'h14
  };

  function automatic logic [7:0] pi_sbox(input logic [7:0] idx);
    return PI_SBOX[idx];
  endfunction

endpackage

// ----- hdl/md2_compress.sv -----
// md2 compression unit: 48-byte rotating work line, one s-box lookup a cycle
// depends on md2_pkg; the lookup is shared with the checksum update
module md2_compress (
  input  logic              clk,
  input  logic              rst,
  input  md2_pkg::cmp_ctl_t ctl,
  input  md2_pkg::block_t   msg_block,
  input  logic [7:0]        ck_index,
  output logic [7:0]        sbox_val,
  output logic              busy,
  output md2_pkg::block_t   hash
);

  localparam logic [5:0] LAST_STEP  = 6'(md2_pkg::WORK_BYTES - 1);
  localparam logic [4:0] LAST_ROUND = 5'(md2_pkg::ROUNDS - 1);

  logic [7:0] x [md2_pkg::WORK_BYTES];
  logic [7:0] t;
  logic [4:0] rnd;
  logic [5:0] step;
  logic [7:0] lookup_idx;
  logic [7:0] mixed;

  // shared s-box: chaining byte while compressing, checksum index otherwise
  always_comb begin
    lookup_idx = busy ? t : ck_index;
    sbox_val   = md2_pkg::pi_sbox(lookup_idx);
    mixed      = x[0] ^ sbox_val;
  end

  // the first 16 bytes of the work line are the chaining value
  always_comb begin
    for (int i = 0; i < md2_pkg::BLK_BYTES; i++) begin
      hash[i] = x[i];
    end
  end

  // while busy the work line shifts by one byte a cycle, the mixed byte entering at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      t    <= '0;
      rnd  <= '0;
      step <= '0;
      for (int k = 0; k < md2_pkg::WORK_BYTES; k++) begin
        x[k] <= '0;
      end
    end else if (ctl.clear) begin
      busy <= 1'b0;
      for (int k = 0; k < md2_pkg::WORK_BYTES; k++) begin
        x[k] <= '0;
      end
    end else if (ctl.start) begin
      busy <= 1'b1;
      t    <= '0;
      rnd  <= '0;
      step <= '0;
      for (int i = 0; i < md2_pkg::BLK_BYTES; i++) begin
        x[md2_pkg::BLK_BYTES + i]     <= msg_block[i];
        x[2 * md2_pkg::BLK_BYTES + i] <= x[i] ^ msg_block[i];
      end
    end else if (busy) begin
      for (int k = 0; k < md2_pkg::WORK_BYTES - 1; k++) begin
        x[k] <= x[k+1];
      end
      x[md2_pkg::WORK_BYTES-1] <= mixed;
      if (step == LAST_STEP) begin
        step <= '0;
        t    <= mixed + {3'b000, rnd};
        if (rnd == LAST_ROUND) begin
          busy <= 1'b0;
        end else begin
          rnd <= rnd + 5'd1;
        end
      end else begin
        step <= step + 6'd1;
        t    <= mixed;
      end
    end
  end

endmodule

// ----- hdl/md2_hash_engine_top.sv -----
// md2 digest engine: block and checksum store, sequencer and digest output
// depends on md2_pkg, md2_compress and assert_macros.svh
//
// usage:
//   msg channel (msg_valid, msg_stall, msg): one word per message byte with
//   cmd absorb, then one word with cmd finish. msg_stall is high whenever
//   the engine is working, so each word waits until the previous is done.
//   dig channel (dig_valid, dig_stall, dig): after a finish, 16 digest bytes,
//   byte 0 first, last_byte set on the sixteenth.
// sequence:
//   an absorb word is taken in IDLE; the byte that fills a 16-byte block
//   adds a load state and a compression (18 rounds of 48 s-box lookups,
//   one per cycle through the single table port), after which the
//   sequencer sees the unit stop and returns to IDLE.
//   finish adds p padding bytes (p = 1..16) and two compressions, each with
//   its load state (message block, then checksum block), then one digest
//   byte per cycle the receiver accepts.
// reset clears chaining value, checksum and fill count; after the last
//   digest byte is taken the engine is back in that state. while dig_stall
//   is high the current digest byte holds and no new word is taken.
`include "assert_macros.svh"

module md2_hash_engine_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          msg_valid,
  output logic          msg_stall,
  input  md2_pkg::in_t  msg,
  output logic          dig_valid,
  input  logic          dig_stall,
  output md2_pkg::out_t dig
);

  typedef enum logic [2:0] {
    IDLE,
    PAD,
    LOAD,
    COMP,
    CKLOAD,
    CKCOMP,
    EMIT
  } state_t;

  localparam logic [3:0] LAST_IDX = 4'(md2_pkg::BLK_BYTES - 1);

  state_t              state;
  logic [3:0]          fill;
  logic [7:0]          carry;
  logic [7:0]          check [md2_pkg::BLK_BYTES];
  logic [7:0]          block [md2_pkg::BLK_BYTES];
  logic [7:0]          pad_val;
  logic                fin;
  logic [3:0]          out_idx;
  logic [3:0]          idx_next;

  logic [7:0]          ab_byte;
  logic [7:0]          ck_index;
  logic [7:0]          sbox_val;
  logic [7:0]          ck_next;
  logic                do_absorb;
  logic                cmp_busy;
  md2_pkg::cmp_ctl_t   cmp_ctl;
  md2_pkg::block_t     cmp_msg;
  md2_pkg::block_t     hash;

  // checksum update path: byte from the port or the padding value
  always_comb begin
    ab_byte   = (state == PAD) ? pad_val : msg.data_byte;
    ck_index  = ab_byte ^ carry;
    ck_next   = check[fill] ^ sbox_val;
    do_absorb = (state == PAD) ||
                (state == IDLE && msg_valid && msg.cmd == md2_pkg::CMD_ABSORB);
    idx_next  = out_idx + 4'd1;
  end

  // compression unit control and block selection
  always_comb begin
    cmp_ctl.start = (state == LOAD) || (state == CKLOAD);
    cmp_ctl.clear = (state == EMIT) && !dig_stall && (out_idx == LAST_IDX);
    for (int i = 0; i < md2_pkg::BLK_BYTES; i++) begin
      cmp_msg[i] = (state == CKLOAD) ? check[i] : block[i];
    end
  end

  assign msg_stall = (state != IDLE);

  md2_compress u_compress (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cmp_ctl),
    .msg_block (cmp_msg),
    .ck_index  (ck_index),
    .sbox_val  (sbox_val),
    .busy      (cmp_busy),
    .hash      (hash)
  );

  // message block store, written one byte per absorb
  always_ff @(posedge clk) begin
    if (do_absorb) begin
      block[fill] <= ab_byte;
    end
  end

  // sequencer, checksum state and registered digest output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      fill      <= '0;
      carry     <= '0;
      fin       <= 1'b0;
      pad_val   <= '0;
      out_idx   <= '0;
      dig_valid <= 1'b0;
      dig       <= '0;
      for (int i = 0; i < md2_pkg::BLK_BYTES; i++) begin
        check[i] <= '0;
      end
    end else begin
      if (do_absorb) begin
        check[fill] <= ck_next;
        carry       <= ck_next;
        fill        <= fill + 4'd1;
      end
      case (state)
        IDLE: begin
          if (msg_valid) begin
            if (msg.cmd == md2_pkg::CMD_FINISH) begin
              fin     <= 1'b1;
              pad_val <= 8'(md2_pkg::BLK_BYTES) - {4'b0000, fill};
              state   <= PAD;
            end else if (fill == LAST_IDX) begin
              state <= LOAD;
            end
          end
        end
        PAD: begin
          if (fill == LAST_IDX) begin
            state <= LOAD;
          end
        end
        LOAD: begin
          state <= COMP;
        end
        COMP: begin
          if (!cmp_busy) begin
            state <= fin ? CKLOAD : IDLE;
          end
        end
        CKLOAD: begin
          state <= CKCOMP;
        end
        CKCOMP: begin
          if (!cmp_busy) begin
            state           <= EMIT;
            dig_valid       <= 1'b1;
            dig.digest_byte <= hash[0];
            dig.last_byte   <= 1'b0;
            out_idx         <= '0;
          end
        end
        EMIT: begin
          if (!dig_stall) begin
            if (out_idx == LAST_IDX) begin
              dig_valid <= 1'b0;
              state     <= IDLE;
              fin       <= 1'b0;
              fill      <= '0;
              carry     <= '0;
              for (int i = 0; i < md2_pkg::BLK_BYTES; i++) begin
                check[i] <= '0;
              end
            end else begin
              out_idx         <= idx_next;
              dig.digest_byte <= hash[idx_next];
              dig.last_byte   <= (idx_next == LAST_IDX);
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // digest words only appear once compression has stopped
  `ASSERT_CLK(a_emit_quiet, dig_valid |-> !cmp_busy, "digest word while compressing")
  // a new compression never starts over a running one
  `ASSERT_CLK(a_start_free, cmp_ctl.start |-> !cmp_busy, "compression restarted while busy")
  // after the final digest word the engine is empty and open for a new message
  `ASSERT_CLK(a_clean_after, (dig_valid && !dig_stall && dig.last_byte) |=>
              (fill == 4'd0 && carry == 8'd0 && !msg_stall && !dig_valid),
              "state not cleared after digest")
  // once reset is sampled high, nothing is offered on the digest side
  `ASSERT_ALWAYS(a_rst_quiet, rst |=> !dig_valid, "digest word right after reset")

endmodule
